FILE: src/tournament_barrier_node_top_assert.svh
// ---------------------------------------------------------------------------
// tournament barrier node assertion macros
// shared concurrent assertion forms, sampled on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef TOURNAMENT_BARRIER_NODE_TOP_ASSERT_SVH
`define TOURNAMENT_BARRIER_NODE_TOP_ASSERT_SVH

// same-cycle implication
`define TBN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tournament barrier node assertion failed");

// next-cycle implication
`define TBN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tournament barrier node assertion failed");

`endif

FILE: src/tbn_pkg.sv
// ---------------------------------------------------------------------------
// tbn_pkg
// types, codes and round/role helpers of the tournament barrier node
// ---------------------------------------------------------------------------
package tbn_pkg;

  // input command codes
  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_MSG    = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // configuration register indexes
  localparam logic REG_NODE_RANK  = 1'b0;
  localparam logic REG_NODE_COUNT = 1'b1;

  // queue between front and back
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    ROLE_NONE,
    ROLE_WINNER,
    ROLE_LOSER,
    ROLE_BYE,
    ROLE_CHAMPION
  } role_e;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_ARRIVE,
    OP_LONE,
    OP_ERR,
    OP_MSG
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] round;
    role_e      role;
    logic [7:0] opp;
  } op_t;

  // configuration view shared by front and back
  typedef struct packed {
    logic [7:0] rank;
    logic [8:0] np;
    logic [3:0] total;
  } cfg_t;

  typedef struct packed {
    role_e      role;
    logic [7:0] opp;
  } role_res_t;

  // number of rounds: smallest l with 2^l >= np
  function automatic logic [3:0] round_total(input logic [8:0] np);
    logic [3:0] l;
    l = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if ((10'd1 << i) >= {1'b0, np}) l = 4'(i);
    end
    return l;
  endfunction

  // role and opponent of a node in round k
  function automatic role_res_t role_of(input logic [3:0] k, input logic [7:0] rank,
                                        input logic [8:0] np);
    logic [16:0] p2;
    logic [16:0] half;
    logic [16:0] rem;
    logic [16:0] rank_x;
    logic [16:0] np_x;
    role_res_t   res;
    p2     = 17'd1 << k;
    half   = p2 >> 1;
    rank_x = {9'd0, rank};
    np_x   = {8'd0, np};
    rem    = rank_x & (p2 - 17'd1);
    res.role = ROLE_NONE;
    res.opp  = 8'd0;
    if (rem == 17'd0) begin
      if (rank_x + half >= np_x) begin
        res.role = ROLE_BYE;
      end else if (p2 < np_x) begin
        res.role = ROLE_WINNER;
        res.opp  = 8'(rank_x + half);
      end
    end
    if (rem == half) begin
      res.role = ROLE_LOSER;
      res.opp  = 8'(rank_x - half);
    end
    if (rank == 8'd0 && p2 >= np_x) begin
      res.role = ROLE_CHAMPION;
      res.opp  = half[7:0];
    end
    return res;
  endfunction

endpackage

FILE: src/tbn_queue.sv
// ---------------------------------------------------------------------------
// tbn_queue
// short fifo of classified operations between front and back
// ---------------------------------------------------------------------------
module tbn_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbn_pkg::op_t   push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tbn_pkg::op_t   pop_data_i_o
);

  localparam int unsigned PtrW = $clog2(tbn_pkg::QDepth);

  tbn_pkg::op_t       mem_q [tbn_pkg::QDepth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]      count_q;

  assign full_o       = (count_q == (PtrW+1)'(tbn_pkg::QDepth));
  assign valid_o      = (count_q != '0);
  assign pop_data_i_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i)      count_q <= count_q + (PtrW+1)'(1);
      else if (!push_i && pop_i) count_q <= count_q - (PtrW+1)'(1);
    end
  end

endmodule

FILE: src/tbn_front.sv
// ---------------------------------------------------------------------------
// tbn_front
// configuration registers, input beat acceptance and static classification
// ---------------------------------------------------------------------------
module tbn_front #(
  parameter int unsigned MAX_ROUNDS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_addr_i,
  input  logic [8:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cmd_i,
  input  logic [3:0]    msg_round_i,
  input  logic [7:0]    msg_source_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output tbn_pkg::op_t  q_data_o,
  output tbn_pkg::cfg_t cfg_o
);

  localparam int unsigned CapInt = (MAX_ROUNDS >= 8) ? 256 : (1 << MAX_ROUNDS);
  localparam logic [8:0]  Cap    = 9'(CapInt);

  logic [7:0] node_rank_q;
  logic [8:0] node_count_q;
  logic [8:0] np;
  logic [3:0] total;
  logic       lone, bad_rank, round_ok, role_ok;
  tbn_pkg::role_res_t rr;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_rank_q  <= 8'd0;
      node_count_q <= 9'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tbn_pkg::REG_NODE_RANK:  node_rank_q  <= cfg_wdata_i[7:0];
        tbn_pkg::REG_NODE_COUNT: node_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective node count and round total
  assign np    = (node_count_q > Cap) ? Cap : node_count_q;
  assign total = tbn_pkg::round_total(np);
  assign cfg_o = '{rank: node_rank_q, np: np, total: total};

  // static checks of the incoming beat
  assign lone     = (np < 9'd2);
  assign bad_rank = ({1'b0, node_rank_q} >= np);
  assign round_ok = (msg_round_i >= 4'd1) && (msg_round_i <= total);
  assign rr       = tbn_pkg::role_of(msg_round_i, node_rank_q, np);
  assign role_ok  = round_ok && (msg_source_i == rr.opp) &&
                    (rr.role == tbn_pkg::ROLE_WINNER || rr.role == tbn_pkg::ROLE_LOSER ||
                     rr.role == tbn_pkg::ROLE_CHAMPION);

  // classification
  always_comb begin
    q_data_o.round = msg_round_i;
    q_data_o.role  = rr.role;
    q_data_o.opp   = rr.opp;
    if (cmd_i == tbn_pkg::CMD_ARRIVE) begin
      if (lone)          q_data_o.op = tbn_pkg::OP_LONE;
      else if (bad_rank) q_data_o.op = tbn_pkg::OP_ERR;
      else               q_data_o.op = tbn_pkg::OP_ARRIVE;
    end else begin
      if (lone || bad_rank || !role_ok) q_data_o.op = tbn_pkg::OP_ERR;
      else                              q_data_o.op = tbn_pkg::OP_MSG;
    end
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

FILE: src/tbn_back.sv
// ---------------------------------------------------------------------------
// tbn_back
// barrier state, round climb and descent engine, result output register
// ---------------------------------------------------------------------------
module tbn_back #(
  parameter int unsigned MAX_ROUNDS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  tbn_pkg::cfg_t cfg_i,
  input  logic          q_valid_i,
  input  tbn_pkg::op_t  q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [7:0]    dest_node_o,
  output logic [3:0]    round_tag_o,
  output logic          last_o
);

  `include "tournament_barrier_node_top_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_CLIMB   = 3'b010,
    ST_DESCEND = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic                    in_barrier_q, in_barrier_d;
  logic [3:0]              wait_round_q, wait_round_d;
  logic [MAX_ROUNDS-1:0]   pending_q, pending_d;
  logic [3:0]              r_q, r_d;

  logic                    out_valid_q;
  logic [1:0]              out_kind_q;
  logic [7:0]              out_dest_q;
  logic [3:0]              out_tag_q;
  logic                    out_last_q;

  logic                    can_emit;
  logic                    emit;
  logic [1:0]              e_kind;
  logic [7:0]              e_dest;
  logic [3:0]              e_tag;
  logic                    e_last;
  logic [MAX_ROUNDS-1:0]   rbit, mbit;
  logic                    r_pend, m_pend;
  tbn_pkg::role_res_t      rr;

  assign can_emit = !out_valid_q || out_ready_i;

  // role and held-message bits of the current round and of the queued message's round
  assign rr     = tbn_pkg::role_of(r_q, cfg_i.rank, cfg_i.np);
  assign rbit   = MAX_ROUNDS'(1) << (4'(r_q - 4'd1));
  assign r_pend = |(pending_q & rbit);
  assign mbit   = MAX_ROUNDS'(1) << (4'(q_data_i.round - 4'd1));
  assign m_pend = |(pending_q & mbit);

  // engine: one round step per cycle while the output register can take a result, at most one result per cycle
  always_comb begin
    state_d      = state_q;
    in_barrier_d = in_barrier_q;
    wait_round_d = wait_round_q;
    pending_d    = pending_q;
    r_d          = r_q;
    q_pop_o      = 1'b0;
    emit         = 1'b0;
    e_kind       = tbn_pkg::KIND_ERROR;
    e_dest       = 8'd0;
    e_tag        = 4'd0;
    e_last       = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && can_emit) begin
          q_pop_o = 1'b1;
          case (q_data_i.op)
            tbn_pkg::OP_ERR: begin
              emit = 1'b1;
            end
            tbn_pkg::OP_LONE: begin
              emit   = 1'b1;
              e_kind = tbn_pkg::KIND_RELEASE;
            end
            tbn_pkg::OP_ARRIVE: begin
              if (in_barrier_q) begin
                emit = 1'b1;
              end else begin
                in_barrier_d = 1'b1;
                r_d          = 4'd1;
                state_d      = ST_CLIMB;
              end
            end
            default: begin
              if (m_pend) begin
                emit = 1'b1;
              end else if (in_barrier_q && wait_round_q == q_data_i.round) begin
                case (q_data_i.role)
                  tbn_pkg::ROLE_WINNER: begin
                    r_d     = q_data_i.round + 4'd1;
                    state_d = ST_CLIMB;
                  end
                  tbn_pkg::ROLE_LOSER: begin
                    r_d     = q_data_i.round - 4'd1;
                    state_d = ST_DESCEND;
                  end
                  default: begin
                    emit    = 1'b1;
                    e_kind  = tbn_pkg::KIND_SEND;
                    e_dest  = q_data_i.opp;
                    e_tag   = q_data_i.round;
                    e_last  = 1'b0;
                    r_d     = q_data_i.round - 4'd1;
                    state_d = ST_DESCEND;
                  end
                endcase
              end else begin
                pending_d = pending_q | mbit;
              end
            end
          endcase
        end
      end
      ST_CLIMB: begin
        if (can_emit) begin
          if (r_q > cfg_i.total) begin
            r_d     = cfg_i.total;
            state_d = ST_DESCEND;
          end else begin
            case (rr.role)
              tbn_pkg::ROLE_WINNER: begin
                if (r_pend) begin
                  pending_d = pending_q & ~rbit;
                  r_d       = r_q + 4'd1;
                end else begin
                  wait_round_d = r_q;
                  state_d      = ST_IDLE;
                end
              end
              tbn_pkg::ROLE_LOSER: begin
                emit   = 1'b1;
                e_kind = tbn_pkg::KIND_SEND;
                e_dest = rr.opp;
                e_tag  = r_q;
                e_last = !r_pend;
                if (r_pend) begin
                  pending_d = pending_q & ~rbit;
                  r_d       = r_q - 4'd1;
                  state_d   = ST_DESCEND;
                end else begin
                  wait_round_d = r_q;
                  state_d      = ST_IDLE;
                end
              end
              tbn_pkg::ROLE_CHAMPION: begin
                if (r_pend) begin
                  pending_d = pending_q & ~rbit;
                  emit      = 1'b1;
                  e_kind    = tbn_pkg::KIND_SEND;
                  e_dest    = rr.opp;
                  e_tag     = r_q;
                  e_last    = 1'b0;
                  r_d       = r_q - 4'd1;
                  state_d   = ST_DESCEND;
                end else begin
                  wait_round_d = r_q;
                  state_d      = ST_IDLE;
                end
              end
              default: begin
                r_d = r_q + 4'd1;
              end
            endcase
          end
        end
      end
      ST_DESCEND: begin
        if (can_emit) begin
          if (r_q == 4'd0) begin
            emit         = 1'b1;
            e_kind       = tbn_pkg::KIND_RELEASE;
            in_barrier_d = 1'b0;
            wait_round_d = 4'd0;
            state_d      = ST_IDLE;
          end else begin
            if (rr.role == tbn_pkg::ROLE_WINNER) begin
              emit   = 1'b1;
              e_kind = tbn_pkg::KIND_SEND;
              e_dest = rr.opp;
              e_tag  = r_q;
              e_last = 1'b0;
            end
            r_d = r_q - 4'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state, cleared again by any register write (all but the round counter)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      in_barrier_q <= 1'b0;
      wait_round_q <= 4'd0;
      pending_q    <= '0;
      r_q          <= 4'd0;
    end else if (cfg_we_i) begin
      state_q      <= ST_IDLE;
      in_barrier_q <= 1'b0;
      wait_round_q <= 4'd0;
      pending_q    <= '0;
    end else begin
      state_q      <= state_d;
      in_barrier_q <= in_barrier_d;
      wait_round_q <= wait_round_d;
      pending_q    <= pending_d;
      r_q          <= r_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_emit) begin
      out_valid_q <= emit;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (can_emit && emit) begin
      out_kind_q <= e_kind;
      out_dest_q <= e_dest;
      out_tag_q  <= e_tag;
      out_last_q <= e_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign dest_node_o = out_dest_q;
  assign round_tag_o = out_tag_q;
  assign last_o      = out_last_q;

  // checks
  `TBN_ASSERT_IMPL(a_busy_in_barrier, state_q != ST_IDLE, in_barrier_q)
  `TBN_ASSERT_IMPL(a_pop_only_idle, q_pop_o, state_q == ST_IDLE)
  `TBN_ASSERT_IMPL(a_release_is_last, emit && e_kind == tbn_pkg::KIND_RELEASE, e_last)
  `TBN_ASSERT_IMPL(a_wait_in_barrier, wait_round_q != 4'd0, in_barrier_q)

endmodule

FILE: src/tournament_barrier_node_top.sv
// an accepted item passes the queue and the back engine; its results leave through the output register
// the back engine takes a new item only when idle, and walks one round per cycle
//   while its output register can take a result
// reset: asynchronous active low; node_rank 0, node_count 2, barrier idle,
//   no held messages; any register write also clears the barrier state
// ---------------------------------------------------------------------------
// tournament_barrier_node_top
// one node of a tournament barrier with front classifier, queue and back engine
// ---------------------------------------------------------------------------
module tournament_barrier_node_top #(
  parameter int unsigned MAX_ROUNDS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // msg_round[3:0], msg_source[11:4], zero[15:12]
  input  logic        s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // dest_node[7:0], round_tag[11:8], zero[15:12]
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast
);

  logic          q_full, q_push, q_valid, q_pop;
  tbn_pkg::op_t  q_in, q_out;
  tbn_pkg::cfg_t cfg;
  logic [7:0]    dest_node;
  logic [3:0]    round_tag;

  // front: registers and classification
  tbn_front #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .msg_round_i  (s_axis_tdata[3:0]),
    .msg_source_i (s_axis_tdata[11:4]),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_in),
    .cfg_o        (cfg)
  );

  // operation queue
  tbn_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (q_in),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .pop_data_i_o (q_out)
  );

  // back: barrier engine
  tbn_back #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .kind_o      (m_axis_tuser),
    .dest_node_o (dest_node),
    .round_tag_o (round_tag),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, round_tag, dest_node};

endmodule

FILE: dv/tournament_barrier_node_top_test.sv
// ---------------------------------------------------------------------------
// tournament_barrier_node_top_test
// self-checking bench for one tournament barrier node: a directed plan of
// register writes and beats, then random phases of full barrier episodes
// (opponent messages in shuffled order around the local arrive) mixed with
// broken episodes and noise; every result beat is checked against a
// cycle-free model of the node's climb and descent
// ---------------------------------------------------------------------------
module tournament_barrier_node_top_test;

  localparam int unsigned ROUND_LIMIT  = 8;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned SETTLE       = 32;
  localparam int unsigned PLAN_LEN     = 33;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [8:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // msg_round[3:0], msg_source[11:4], zero[15:12]
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // dest_node[7:0], round_tag[11:8], zero[15:12]
  logic [1:0]  m_axis_tuser;   // kind
  logic        m_axis_tlast;

  tournament_barrier_node_top #(
    .MAX_ROUNDS(ROUND_LIMIT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  typedef struct {
    logic [1:0] kind;
    logic [7:0] dest;
    logic [3:0] tag;
    logic       last;
  } notice_t;

  typedef struct {
    tbn_pkg::role_e role;
    int unsigned    opp;
  } seat_t;

  typedef struct {
    logic       cmd;
    logic [3:0] rnd;
    logic [7:0] src;
  } item_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_ITEM,
    ROW_ITEM_CHK
  } row_e;

  typedef struct packed {
    row_e       rk;
    logic       addr;
    logic [8:0] wdata;
    logic       cmd;
    logic [3:0] rnd;
    logic [7:0] src;
    logic [1:0] kind;
  } row_t;

  // directed plan: typed kind only on single-beat errors and releases
  localparam row_t PLAN [0:PLAN_LEN-1] = '{
    // after reset: rank 0, two nodes, champion in round 1
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd0, 8'd0, tbn_pkg::KIND_ERROR},
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd15, 8'd255, tbn_pkg::KIND_ERROR},
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd1, 8'd0, tbn_pkg::KIND_ERROR},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_ERROR},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd1, 8'd1, tbn_pkg::KIND_SEND},
    // early message held, then repeated, then consumed by the arrive
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd1, 8'd1, tbn_pkg::KIND_SEND},
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd1, 8'd1, tbn_pkg::KIND_ERROR},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    // lone node
    '{ROW_CFG, tbn_pkg::REG_NODE_COUNT, 9'd1,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_RELEASE},
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd1, 8'd0, tbn_pkg::KIND_ERROR},
    // count clamped to 256, top rank loses in round 1
    '{ROW_CFG, tbn_pkg::REG_NODE_COUNT, 9'd511,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    '{ROW_CFG, tbn_pkg::REG_NODE_RANK, 9'h1ff,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd1, 8'd254, tbn_pkg::KIND_SEND},
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd2, 8'd0, tbn_pkg::KIND_ERROR},
    // rank 0 of 256: every message early, then one arrive gives nine beats
    '{ROW_CFG, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd8, 8'd128, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd1, 8'd1, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd2, 8'd2, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd3, 8'd4, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd4, 8'd8, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd5, 8'd16, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd6, 8'd32, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd7, 8'd64, tbn_pkg::KIND_SEND},
    '{ROW_ITEM, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    // rank out of range
    '{ROW_CFG, tbn_pkg::REG_NODE_COUNT, 9'd3,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    '{ROW_CFG, tbn_pkg::REG_NODE_RANK, 9'd5,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_ERROR},
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_MSG, 4'd1, 8'd4, tbn_pkg::KIND_ERROR},
    // zero count counts as a lone node
    '{ROW_CFG, tbn_pkg::REG_NODE_COUNT, 9'd0,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_SEND},
    '{ROW_ITEM_CHK, tbn_pkg::REG_NODE_RANK, 9'd0,
      tbn_pkg::CMD_ARRIVE, 4'd0, 8'd0, tbn_pkg::KIND_RELEASE}
  };

  // node model state
  int unsigned node_rank;
  int unsigned node_count;
  bit          in_barrier;
  int unsigned wait_round;
  bit [7:0]    held_msgs;

  notice_t     notice_q[$];
  notice_t     step_notices[$];
  int unsigned mismatches;
  int unsigned items_sent;
  bit          steady;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tournament_barrier_node_top_test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // node model
  // ---------------------------------------------------------------------------

  function automatic int unsigned live_nodes();
    int unsigned np;
    np = node_count;
    if (np > (1 << ROUND_LIMIT)) np = 1 << ROUND_LIMIT;
    if (np > 256) np = 256;
    return np;
  endfunction

  function automatic int unsigned rounds_for(int unsigned np);
    int unsigned l;
    l = 0;
    while (l < ROUND_LIMIT && (1 << l) < np) l++;
    return l;
  endfunction

  // role and opponent in round k from the power-of-two masks
  function automatic seat_t seat_in(int unsigned k, int unsigned np);
    seat_t       s;
    int unsigned p2;
    int unsigned half;
    int unsigned rem;
    p2     = 1 << k;
    half   = p2 >> 1;
    rem    = node_rank & (p2 - 1);
    s.role = tbn_pkg::ROLE_NONE;
    s.opp  = 0;
    if (rem == 0) begin
      if (node_rank + half >= np) begin
        s.role = tbn_pkg::ROLE_BYE;
      end else if (p2 < np) begin
        s.role = tbn_pkg::ROLE_WINNER;
        s.opp  = node_rank + half;
      end
    end
    if (rem == half) begin
      s.role = tbn_pkg::ROLE_LOSER;
      s.opp  = node_rank - half;
    end
    if (node_rank == 0 && p2 >= np) begin
      s.role = tbn_pkg::ROLE_CHAMPION;
      s.opp  = half;
    end
    return s;
  endfunction

  function automatic void add_notice(logic [1:0] kind, int unsigned dest, int unsigned tag);
    notice_t n;
    n.kind = kind;
    n.dest = 8'(dest);
    n.tag  = 4'(tag);
    n.last = 1'b0;
    step_notices.push_back(n);
  endfunction

  // wake every lower round won, then release
  function automatic void descend(int from, int unsigned np);
    seat_t s;
    for (int r = from; r >= 1; r--) begin
      s = seat_in(r, np);
      if (s.role == tbn_pkg::ROLE_WINNER) add_notice(tbn_pkg::KIND_SEND, s.opp, r);
    end
    add_notice(tbn_pkg::KIND_RELEASE, 0, 0);
    in_barrier = 1'b0;
    wait_round = 0;
  endfunction

  // walk up from a round, using held messages where they exist
  function automatic void climb(int unsigned start, int unsigned np);
    int unsigned total;
    seat_t       s;
    total = rounds_for(np);
    for (int r = start; r <= total; r++) begin
      s = seat_in(r, np);
      if (s.role == tbn_pkg::ROLE_WINNER) begin
        if (held_msgs[r-1]) begin
          held_msgs[r-1] = 1'b0;
        end else begin
          wait_round = r;
          return;
        end
      end else if (s.role == tbn_pkg::ROLE_LOSER) begin
        add_notice(tbn_pkg::KIND_SEND, s.opp, r);
        if (held_msgs[r-1]) begin
          held_msgs[r-1] = 1'b0;
          descend(r - 1, np);
        end else begin
          wait_round = r;
        end
        return;
      end else if (s.role == tbn_pkg::ROLE_CHAMPION) begin
        if (held_msgs[r-1]) begin
          held_msgs[r-1] = 1'b0;
          add_notice(tbn_pkg::KIND_SEND, s.opp, r);
          descend(r - 1, np);
        end else begin
          wait_round = r;
        end
        return;
      end
    end
    descend(total, np);
  endfunction

  // notices caused by one input beat, left in step_notices
  function automatic void barrier_step(logic cmd, logic [3:0] rnd, logic [7:0] src);
    int unsigned np;
    int unsigned total;
    seat_t       s;
    np = live_nodes();
    step_notices.delete();
    if (cmd == tbn_pkg::CMD_ARRIVE) begin
      if (in_barrier) begin
        add_notice(tbn_pkg::KIND_ERROR, 0, 0);
      end else if (np < 2) begin
        add_notice(tbn_pkg::KIND_RELEASE, 0, 0);
      end else if (node_rank >= np) begin
        add_notice(tbn_pkg::KIND_ERROR, 0, 0);
      end else begin
        in_barrier = 1'b1;
        climb(1, np);
      end
    end else if (np < 2 || node_rank >= np) begin
      add_notice(tbn_pkg::KIND_ERROR, 0, 0);
    end else begin
      total  = rounds_for(np);
      s.role = tbn_pkg::ROLE_NONE;
      s.opp  = 0;
      if (rnd >= 1 && rnd <= total) s = seat_in(rnd, np);
      if ((s.role != tbn_pkg::ROLE_WINNER && s.role != tbn_pkg::ROLE_LOSER &&
           s.role != tbn_pkg::ROLE_CHAMPION) || src != s.opp) begin
        add_notice(tbn_pkg::KIND_ERROR, 0, 0);
      end else if (held_msgs[rnd-1]) begin
        add_notice(tbn_pkg::KIND_ERROR, 0, 0);
      end else if (in_barrier && wait_round == rnd) begin
        if (s.role == tbn_pkg::ROLE_WINNER) begin
          climb(rnd + 1, np);
        end else if (s.role == tbn_pkg::ROLE_LOSER) begin
          descend(rnd - 1, np);
        end else begin
          add_notice(tbn_pkg::KIND_SEND, s.opp, rnd);
          descend(rnd - 1, np);
        end
      end else begin
        held_msgs[rnd-1] = 1'b1;
      end
    end
    if (step_notices.size() > 0) step_notices[step_notices.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one input beat; typed rows replace the model's notices with a fixed one
  task automatic send_item(item_t it, bit typed, logic [1:0] kind);
    int unsigned gap;
    notice_t     n;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {4'd0, it.src, it.rnd};
    s_axis_tuser  <= it.cmd;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    barrier_step(it.cmd, it.rnd, it.src);
    if (typed) begin
      n.kind = kind;
      n.dest = 8'd0;
      n.tag  = 4'd0;
      n.last = 1'b1;
      notice_q.push_back(n);
    end else begin
      foreach (step_notices[i]) notice_q.push_back(step_notices[i]);
    end
    items_sent++;
  endtask

  // hold the sender until every expected beat is out and the node is idle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (notice_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic addr, logic [8:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (addr == tbn_pkg::REG_NODE_RANK) node_rank = data[7:0];
    else node_count = data;
    in_barrier = 1'b0;
    wait_round = 0;
    held_msgs  = '0;
  endtask

  // any beat at all, biased toward valid rounds and real opponents
  function automatic item_t noise_item();
    item_t       it;
    seat_t       s;
    int unsigned total;
    total  = rounds_for(live_nodes());
    it.cmd = 1'($urandom_range(0, 1));
    if (total == 0 || $urandom_range(0, 1) == 0) it.rnd = 4'($urandom_range(0, 15));
    else it.rnd = 4'($urandom_range(1, total));
    if ($urandom_range(0, 1) == 0) begin
      it.src = 8'($urandom_range(0, 255));
    end else begin
      s      = seat_in(it.rnd, live_nodes());
      it.src = 8'(s.opp);
    end
    return it;
  endfunction

  // arrive plus every opponent message of one barrier, shuffled;
  // a broken episode drops, repeats or adds one beat
  task automatic play_episode(bit broken);
    item_t       seq[$];
    item_t       it;
    seat_t       s;
    int unsigned np;
    int unsigned j;
    np = live_nodes();
    for (int r = 1; r <= rounds_for(np); r++) begin
      s = seat_in(r, np);
      if (s.role == tbn_pkg::ROLE_WINNER || s.role == tbn_pkg::ROLE_LOSER ||
          s.role == tbn_pkg::ROLE_CHAMPION) begin
        it.cmd = tbn_pkg::CMD_MSG;
        it.rnd = 4'(r);
        it.src = 8'(s.opp);
        seq.push_back(it);
        if (s.role != tbn_pkg::ROLE_WINNER) break;
      end
    end
    for (int i = seq.size() - 1; i > 0; i--) begin
      j      = $urandom_range(0, i);
      it     = seq[i];
      seq[i] = seq[j];
      seq[j] = it;
    end
    it.cmd = tbn_pkg::CMD_ARRIVE;
    it.rnd = 4'($urandom_range(0, 15));
    it.src = 8'($urandom_range(0, 255));
    seq.insert($urandom_range(0, seq.size()), it);
    if (broken) begin
      case ($urandom_range(0, 2))
        0: seq.delete($urandom_range(0, seq.size() - 1));
        1: seq.insert($urandom_range(0, seq.size()), seq[$urandom_range(0, seq.size() - 1)]);
        default: seq.insert($urandom_range(0, seq.size()), noise_item());
      endcase
    end
    foreach (seq[i]) send_item(seq[i], 1'b0, tbn_pkg::KIND_SEND);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // receiver stalls
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        if (stall_left > 0) begin
          m_axis_tready <= 1'b0;
          stall_left--;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // compare each result beat with the oldest expected notice
  always @(posedge clk_i) begin
    notice_t n;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (notice_q.size() == 0) begin
        $error("unexpected result beat: kind %0d dest %0d tag %0d",
               m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[11:8]);
        mismatches++;
      end else begin
        n = notice_q.pop_front();
        if (m_axis_tuser !== n.kind) begin
          $error("kind: expected %0d, got %0d", n.kind, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[7:0] !== n.dest) begin
          $error("dest_node: expected %0d, got %0d", n.dest, m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tdata[11:8] !== n.tag) begin
          $error("round_tag: expected %0d, got %0d", n.tag, m_axis_tdata[11:8]);
          mismatches++;
        end
        if (m_axis_tlast !== n.last) begin
          $error("last: expected %0d, got %0d", n.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    item_t       it;
    int unsigned cnt;
    int unsigned rank;
    int unsigned np;
    bit          rank_first;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = tbn_pkg::REG_NODE_RANK;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = tbn_pkg::CMD_ARRIVE;
    mismatches    = 0;
    items_sent    = 0;
    steady        = 1'b0;
    node_rank     = 0;
    node_count    = 2;
    in_barrier    = 1'b0;
    wait_round    = 0;
    held_msgs     = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed plan
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (PLAN[i].rk == ROW_CFG) begin
        drain();
        cfg_write(PLAN[i].addr, PLAN[i].wdata);
      end else begin
        it.cmd = PLAN[i].cmd;
        it.rnd = PLAN[i].rnd;
        it.src = PLAN[i].src;
        send_item(it, PLAN[i].rk == ROW_ITEM_CHK, PLAN[i].kind);
      end
    end

    // random phases, each under a fresh node setting
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain();
      steady = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9)) inside
        0:       cnt = 2;
        1:       cnt = 256;
        2:       cnt = $urandom_range(257, 511);
        3:       cnt = $urandom_range(0, 1);
        4, 5:    cnt = $urandom_range(3, 16);
        default: cnt = $urandom_range(2, 256);
      endcase
      np = (cnt > 256) ? 256 : cnt;
      if (np >= 2 && $urandom_range(0, 7) != 0) begin
        rank = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, np - 1);
      end else begin
        rank = $urandom_range(0, 255);
      end
      rank_first = 1'($urandom_range(0, 1));
      if (rank_first) begin
        cfg_write(tbn_pkg::REG_NODE_RANK, {1'($urandom_range(0, 1)), 8'(rank)});
      end
      cfg_write(tbn_pkg::REG_NODE_COUNT, 9'(cnt));
      if (!rank_first) begin
        cfg_write(tbn_pkg::REG_NODE_RANK, {1'($urandom_range(0, 1)), 8'(rank)});
      end

      if (np < 2 || rank >= np) begin
        repeat ($urandom_range(3, 6)) send_item(noise_item(), 1'b0, tbn_pkg::KIND_SEND);
      end else begin
        repeat ($urandom_range(1, 5)) begin
          play_episode($urandom_range(0, 4) == 0);
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(noise_item(), 1'b0, tbn_pkg::KIND_SEND);
          end
          if ($urandom_range(0, 3) == 0) drain();
        end
      end
    end

    // wind down
    drain();
    if (mismatches == 0) begin
      $display("tournament_barrier_node_top_test passed");
    end else begin
      $display("tournament_barrier_node_top_test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/tbn_pkg.sv
src/tbn_queue.sv
src/tbn_front.sv
src/tbn_back.sv
src/tournament_barrier_node_top.sv
dv/tournament_barrier_node_top_test.sv
